FILE: src/clc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and codes of the circular list unit.
// ----------------------------------------------------------------------------
package clc_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT  = 3'd0,
    ACT_GET     = 3'd1,
    ACT_DEL_POS = 3'd2,
    ACT_DEL_VAL = 3'd3,
    ACT_CURRENT = 3'd4,
    ACT_NEXT    = 3'd5,
    ACT_RESET   = 3'd6,
    ACT_CLEAR   = 3'd7
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_SEARCH,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_READ,
    ST_READ_WAIT,
    ST_FINISH,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word
    logic mod_step;   // one subtract step of the position reduction
    logic scan_step;  // compare the read entry and advance the scan index
    logic up_step;    // move one entry up during an insert
    logic dn_step;    // move one entry down during a delete
    logic rd_issue;   // read the entry at the target index
    logic finish;     // apply the action to length and cursor and register the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    mod_done;
    logic    found;
    logic    scan_end;
    logic    up_done;
    logic    dn_done;
    logic    empty;
    logic    full;
    logic    cur_ok;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/clc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clc_ctrl
// Sequencer that steps the datapath through one action at a time.
// ----------------------------------------------------------------------------
module clc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire clc_pkg::sts_t  sts_i,
  output clc_pkg::cmd_t       cmd_o
);

  clc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      clc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = clc_pkg::ST_MOD;
      end
      clc_pkg::ST_MOD: begin
        if (sts_i.mod_done) begin
          case (sts_i.action)
            clc_pkg::ACT_INSERT:
              state_d = sts_i.full ? clc_pkg::ST_FINISH : clc_pkg::ST_SHIFT_UP;
            clc_pkg::ACT_DEL_VAL:
              state_d = clc_pkg::ST_SEARCH;
            clc_pkg::ACT_GET, clc_pkg::ACT_DEL_POS, clc_pkg::ACT_RESET:
              state_d = sts_i.empty ? clc_pkg::ST_FINISH : clc_pkg::ST_READ;
            clc_pkg::ACT_CURRENT, clc_pkg::ACT_NEXT:
              state_d = sts_i.cur_ok ? clc_pkg::ST_READ : clc_pkg::ST_FINISH;
            default: state_d = clc_pkg::ST_FINISH;
          endcase
        end
      end
      clc_pkg::ST_SEARCH: begin
        // A scan step issues a read; the compare lands in the following cycle.
        if (sts_i.found) state_d = clc_pkg::ST_READ;
        else if (sts_i.scan_end) state_d = clc_pkg::ST_FINISH;
      end
      clc_pkg::ST_SHIFT_UP: begin
        if (sts_i.up_done) state_d = clc_pkg::ST_FINISH;
      end
      clc_pkg::ST_READ: state_d = clc_pkg::ST_READ_WAIT;
      clc_pkg::ST_READ_WAIT: begin
        if (sts_i.action == clc_pkg::ACT_DEL_POS || sts_i.action == clc_pkg::ACT_DEL_VAL)
          state_d = clc_pkg::ST_SHIFT_DN;
        else
          state_d = clc_pkg::ST_FINISH;
      end
      clc_pkg::ST_SHIFT_DN: begin
        if (sts_i.dn_done) state_d = clc_pkg::ST_FINISH;
      end
      clc_pkg::ST_FINISH: state_d = clc_pkg::ST_OUT;
      clc_pkg::ST_OUT: begin
        if (out_ready_i) state_d = clc_pkg::ST_IDLE;
      end
      default: state_d = clc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      clc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      clc_pkg::ST_MOD:       cmd_o.mod_step  = 1'b1;
      clc_pkg::ST_SEARCH:    cmd_o.scan_step = 1'b1;
      clc_pkg::ST_SHIFT_UP:  cmd_o.up_step   = 1'b1;
      clc_pkg::ST_SHIFT_DN:  cmd_o.dn_step   = 1'b1;
      clc_pkg::ST_READ:      cmd_o.rd_issue  = 1'b1;
      clc_pkg::ST_READ_WAIT: ;
      clc_pkg::ST_FINISH:    cmd_o.finish    = 1'b1;
      clc_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/clc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clc_dp
// Entry memory, position reduction, shift and search datapath.
// ----------------------------------------------------------------------------
module clc_dp #(
  parameter int CAPACITY     = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic [2:0]    action_i,
  input  wire logic [15:0]   position_i,
  input  wire logic [31:0]   value_i,
  input  wire logic          rst_ni,
  input  wire clc_pkg::cmd_t cmd_i,
  output clc_pkg::sts_t      sts_o,
  output logic               ok_o,
  output logic [31:0]        result_value_o,
  output logic [6:0]         count_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [HANDLE_WIDTH-1:0] mem [CAPACITY];
  logic [HANDLE_WIDTH-1:0] rd_q;
  logic [HANDLE_WIDTH-1:0] sh_q;     // entry in transit during a shift
  logic                    sh_v_q;   // sh_q holds an entry still to be written

  clc_pkg::action_e   act_q;
  logic [15:0]        pos_q;
  logic [HANDLE_WIDTH-1:0] val_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [IW-1:0]      cur_q, cur_d;
  logic               cv_q, cv_d;
  logic [CW-1:0]      idx_q;     // target index
  logic [CW-1:0]      wk_q;      // shift / scan pointer
  logic               cmp_q;     // a scan read is in flight
  logic               found_q;
  logic               ok_q;
  logic [31:0]        res_q;
  logic [HANDLE_WIDTH-1:0] mask_val;
  logic               ok_d;
  logic [31:0]        res_d;
  logic [CW-1:0]      nm1;

  // Reduction target: insert uses (pos-1) mod n (pos 0 gives 0), get and delete at position use pos mod n.
  logic [16:0] rem_q;
  logic        ins_off;
  logic        pos_act;
  logic [16:0] cnt_ext;

  assign cnt_ext  = 17'(cnt_q);
  assign ins_off  = (act_q == clc_pkg::ACT_INSERT) && (pos_q != 16'd0) && (cnt_q != '0);
  assign pos_act  = (act_q == clc_pkg::ACT_INSERT) || (act_q == clc_pkg::ACT_GET) ||
                    (act_q == clc_pkg::ACT_DEL_POS);
  assign mask_val = val_q;
  assign nm1      = cnt_q - CW'(1);

  assign sts_o.action   = act_q;
  assign sts_o.mod_done = !pos_act || (cnt_q == '0) || (rem_q < cnt_ext);
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.full     = (cnt_q >= CW'(CAPACITY));
  assign sts_o.cur_ok   = cv_q && (CW'(cur_q) < cnt_q);
  assign sts_o.found    = cmp_q && (rd_q == val_q);
  assign sts_o.scan_end = !cmp_q && (wk_q >= cnt_q);
  assign sts_o.up_done  = (wk_q <= idx_q) && !sh_v_q;
  assign sts_o.dn_done  = (wk_q + CW'(1) >= cnt_q) && !sh_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cur_q <= '0;
      cv_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      cv_q  <= cv_d;
    end
  end

  // Memory port: one write and registered reads. A shift reads one entry
  // ahead into sh_q and writes it to its new place on the next cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.up_step) begin
      if (sh_v_q)             mem[IW'(wk_q + CW'(1))] <= sh_q;
      else if (wk_q <= idx_q) mem[idx_q[IW-1:0]] <= val_q;
      if (wk_q > idx_q)       sh_q <= mem[IW'(wk_q - CW'(1))];
    end else if (cmd_i.dn_step) begin
      if (sh_v_q)                mem[IW'(wk_q - CW'(1))] <= sh_q;
      if (wk_q + CW'(1) < cnt_q) sh_q <= mem[IW'(wk_q + CW'(1))];
    end
    if (cmd_i.rd_issue) rd_q <= mem[idx_q[IW-1:0]];
    else if (cmd_i.scan_step && wk_q < cnt_q) rd_q <= mem[wk_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= clc_pkg::action_e'(action_i);
      pos_q <= position_i;
      val_q <= HANDLE_WIDTH'(value_i);
      rem_q <= 17'(position_i) - ((action_i == clc_pkg::ACT_INSERT && position_i != 16'd0)
               ? 17'd1 : 17'd0);
      wk_q  <= '0;
      cmp_q <= 1'b0;
      found_q <= 1'b0;
      sh_v_q  <= 1'b0;
    end
    if (cmd_i.mod_step) begin
      if (!sts_o.mod_done) begin
        rem_q <= rem_q - cnt_ext;
      end else begin
        case (act_q)
          clc_pkg::ACT_INSERT: begin
            idx_q <= ins_off ? CW'(rem_q) + CW'(1) : '0;
            wk_q  <= cnt_q;
          end
          clc_pkg::ACT_CURRENT, clc_pkg::ACT_NEXT: idx_q <= CW'(cur_q);
          clc_pkg::ACT_RESET:  idx_q <= '0;
          clc_pkg::ACT_DEL_VAL: wk_q <= '0;
          default: begin
            idx_q <= CW'(rem_q);
            wk_q  <= CW'(rem_q);
          end
        endcase
      end
    end
    if (cmd_i.scan_step) begin
      cmp_q <= (wk_q < cnt_q) && !sts_o.found;
      if (sts_o.found) begin
        idx_q   <= wk_q - CW'(1);
        wk_q    <= wk_q - CW'(1);
        found_q <= 1'b1;
      end else if (wk_q < cnt_q) begin
        wk_q <= wk_q + CW'(1);
      end
    end
    if (cmd_i.up_step) begin
      sh_v_q <= (wk_q > idx_q);
      if (wk_q > idx_q) wk_q <= wk_q - CW'(1);
    end
    if (cmd_i.dn_step) begin
      sh_v_q <= (wk_q + CW'(1) < cnt_q);
      if (wk_q + CW'(1) < cnt_q) wk_q <= wk_q + CW'(1);
    end
    if (cmd_i.finish) begin
      ok_q  <= ok_d;
      res_q <= ok_d ? res_d : 32'd0;
    end
  end

  always_comb begin
    ok_d  = 1'b0;
    res_d = 32'(rd_q);
    cnt_d = cnt_q;
    cur_d = cur_q;
    cv_d  = cv_q;
    if (cmd_i.finish) begin
      case (act_q)
        clc_pkg::ACT_INSERT: begin
          if (!sts_o.full) begin
            ok_d  = 1'b1;
            res_d = 32'(mask_val);
            cnt_d = cnt_q + CW'(1);
            if (cnt_q == '0) begin
              cur_d = '0;
              cv_d  = 1'b1;
            end else if (cv_q && CW'(cur_q) >= idx_q) begin
              cur_d = cur_q + IW'(1);
            end
          end
        end
        clc_pkg::ACT_GET: ok_d = !sts_o.empty;
        clc_pkg::ACT_DEL_POS, clc_pkg::ACT_DEL_VAL: begin
          ok_d = (act_q == clc_pkg::ACT_DEL_POS) ? !sts_o.empty : found_q;
          if (ok_d) begin
            cnt_d = nm1;
            if (nm1 == '0) begin
              cur_d = '0;
              cv_d  = 1'b0;
            end else if (cv_q) begin
              if (CW'(cur_q) > idx_q) cur_d = cur_q - IW'(1);
              else if (CW'(cur_q) == idx_q && idx_q == nm1) cur_d = '0;
            end
          end
        end
        clc_pkg::ACT_CURRENT: ok_d = sts_o.cur_ok;
        clc_pkg::ACT_NEXT: begin
          ok_d = sts_o.cur_ok;
          if (ok_d) cur_d = (CW'(cur_q) + CW'(1) >= cnt_q) ? '0 : cur_q + IW'(1);
        end
        clc_pkg::ACT_RESET: begin
          ok_d = !sts_o.empty;
          if (ok_d) begin
            cur_d = '0;
            cv_d  = 1'b1;
          end
        end
        default: begin
          ok_d  = 1'b1;
          res_d = 32'd0;
          cnt_d = '0;
          cur_d = '0;
          cv_d  = 1'b0;
        end
      endcase
    end
  end

  assign ok_o           = ok_q;
  assign result_value_o = res_q;
  assign count_o        = 7'(cnt_q);

endmodule
`default_nettype wire

FILE: src/circular_list_with_cursor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_list_with_cursor_unit
// Bounded circular list of handles with a cursor, one action per word.
// ----------------------------------------------------------------------------
// Steps per word: clear goes straight to finish; get, current, next and cursor reset
// read one entry; insert shifts entries up; delete at position reads and then shifts
// down; delete by value scans, reads and shifts down. Insert, get and delete at position
// first reduce the position by repeated subtraction of the length.
// Words are handled one at a time; a new word can be taken in the cycle after the result leaves.
// Reset: length zero and no cursor; entry contents stay undefined until written.
module circular_list_with_cursor_unit #(
  parameter int CAPACITY     = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [15:0] position_i,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ok_o,
  output logic [31:0]      result_value_o,
  output logic [6:0]       count_o
);

  clc_pkg::cmd_t cmd;
  clc_pkg::sts_t sts;

  clc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  clc_dp #(.CAPACITY(CAPACITY), .HANDLE_WIDTH(HANDLE_WIDTH)) u_dp (
    .clk_i, .action_i, .position_i, .value_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts), .ok_o, .result_value_o, .count_o
  );

endmodule
`default_nettype wire
